// File: hdl/otc_pkg.sv
`default_nettype none

package otc_pkg;

  localparam int unsigned VAL_W    = 16;
  localparam int unsigned ENERGY_W = 40;
  localparam int unsigned IN_W     = 64;
  localparam int unsigned OUT_W    = 48;
  localparam int unsigned PROD_W   = 2 * VAL_W;
  localparam int unsigned SUM_W    = PROD_W + 2;

  localparam logic [ENERGY_W-1:0] LIMIT_RESET = {ENERGY_W{1'b1}};

  // Energy weights: sum over the three pairs of 60x^2 + 16xy + 4y^2
  // collapses to 64 * (sum of squares) + 16 * (sum of cross products).
  localparam int unsigned SQ_SHIFT = 6;
  localparam int unsigned XY_SHIFT = 4;

  localparam logic [2:0] FANO_K1 = 3'(7);
  localparam logic [2:0] FANO_K2 = 3'(13);

  typedef logic [VAL_W-1:0]    val_t;
  typedef logic [ENERGY_W-1:0] energy_t;

  typedef struct packed {
    logic       closure_ok;
    logic       fano_ok;
    logic [2:0] line_code;
    logic [1:0] parity_class;
  } check_t;

  function automatic val_t mix16(input val_t v, input val_t s);
    return {v[14:0], v[15]} ^ {v[12:0], v[15:13]} ^ {v[1:0], v[15:2]} ^ s;
  endfunction

  // Only the low bits of the products survive the 3-bit mask.
  function automatic logic [2:0] fano3(input val_t v);
    logic [2:0] lo;
    lo = v[2:0];
    return 3'(lo * FANO_K1) ^ v[5:3] ^ 3'(lo * FANO_K2);
  endfunction

  function automatic logic [1:0] tetra2(input val_t v);
    return {v[1] ^ v[2] ^ v[3], v[0] ^ v[1] ^ v[2]};
  endfunction

endpackage

`default_nettype wire

// File: hdl/orbit_triple_check_top.sv
// Channel   Dir  Handshake         Payload
// s_axis    in   s_tvalid/tready   s_tdata: val_a, val_b, val_c, mix_seed
// m_axis    out  m_tvalid/tready   m_tdata: accepted, line_code, parity_class, energy
// cfg       in   cfg_we            cfg_wdata: energy_limit
//
// One item enters per cycle while the output is not stalled; each accepted item passes
// through the input register, the product stage, the sum stage and the
// limit compare into the result register.
// Every stage holds while the next is full and stalled, so bubbles are squeezed out.
// Reset clears the stage valid bits and sets the limit to all ones.
`default_nettype none

module orbit_triple_check_top (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire  [otc_pkg::IN_W-1:0]    s_tdata,   // val_a, val_b, val_c, mix_seed
  output logic                        m_tvalid,
  input  wire                         m_tready,
  output logic [otc_pkg::OUT_W-1:0]   m_tdata,   // accepted, line_code, parity_class, energy, pad
  input  wire                         cfg_we,
  input  wire  [otc_pkg::ENERGY_W-1:0] cfg_wdata
);
  import otc_pkg::*;

  energy_t energy_limit;

  logic v1, v2, v3;
  logic r1, r2, r3, ro;

  val_t a1, b1, c1, s1;

  logic [PROD_W-1:0] aa2, bb2, cc2, ab2, bc2, ca2;
  check_t chk2, chk2_next;

  logic [SUM_W-1:0] sq3, xy3;
  check_t chk3;

  logic    accepted_q;
  logic [2:0] fano_q;
  logic [1:0] tetra_q;
  energy_t energy_q;

  energy_t energy_next;
  logic    ok_next;
  logic [2:0] fa, fb, fc;

  assign ro = !m_tvalid || m_tready;
  assign r3 = !v3 || ro;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s_tready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      energy_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (ro) m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && s_tvalid) begin
      a1 <= s_tdata[VAL_W-1:0];
      b1 <= s_tdata[2*VAL_W-1:VAL_W];
      c1 <= s_tdata[3*VAL_W-1:2*VAL_W];
      s1 <= s_tdata[4*VAL_W-1:3*VAL_W];
    end
  end

  always_comb begin
    fa = fano3(a1);
    fb = fano3(b1);
    fc = fano3(c1);
    chk2_next.closure_ok   = (mix16(a1, s1) ^ mix16(b1, s1) ^ mix16(c1, s1)) == s1;
    chk2_next.fano_ok      = (fa != fb) && (fb != fc) && (fc != fa) &&
                             ((fa ^ fb ^ fc) == 3'd0);
    chk2_next.line_code    = fa ^ fb;
    chk2_next.parity_class = tetra2(a1);
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      aa2  <= a1 * a1;
      bb2  <= b1 * b1;
      cc2  <= c1 * c1;
      ab2  <= a1 * b1;
      bc2  <= b1 * c1;
      ca2  <= c1 * a1;
      chk2 <= chk2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      sq3  <= SUM_W'(aa2) + SUM_W'(bb2) + SUM_W'(cc2);
      xy3  <= SUM_W'(ab2) + SUM_W'(bc2) + SUM_W'(ca2);
      chk3 <= chk2;
    end
  end

  always_comb begin
    energy_next = ENERGY_W'({sq3, SQ_SHIFT'(0)}) + ENERGY_W'({xy3, XY_SHIFT'(0)});
    ok_next     = chk3.closure_ok && chk3.fano_ok && (energy_next <= energy_limit);
  end

  always_ff @(posedge clk) begin
    if (ro && v3) begin
      accepted_q <= ok_next;
      fano_q     <= ok_next ? chk3.line_code : 3'd0;
      tetra_q    <= ok_next ? chk3.parity_class : 2'd0;
      energy_q   <= ok_next ? energy_next : '0;
    end
  end

  assign m_tdata = {2'b00, energy_q, tetra_q, fano_q, accepted_q};

`ifndef SYNTH
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[45:1] == '0)
    else $error("rejected result carries nonzero fields");

  a_accept_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[45:6] <= energy_limit)
    else $error("accepted result above energy limit");

  a_accept_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[3:1] != 3'd0)
    else $error("accepted result with zero fano line");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while output is free");
`endif

endmodule

`default_nettype wire
